@@ rtl/core/aprs_position_text_formatter_top_assert.svh @@
// Assertion macros shared by the position formatter modules.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef APRS_POSITION_TEXT_FORMATTER_TOP_ASSERT_SVH
`define APRS_POSITION_TEXT_FORMATTER_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define APRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define APRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/aprs_pos_pkg.sv @@
`timescale 1ns / 1ps
package aprs_pos_pkg;

  localparam int unsigned AngleW = 29;
  localparam int unsigned MagW   = 28;
  localparam int unsigned AmbW   = 3;
  localparam int unsigned NChars = 9;

  // Clamp limits in microdegrees.
  localparam logic signed [AngleW-1:0] LatLimit = 29'sd90000000;
  localparam logic signed [AngleW-1:0] LonLimit = 29'sd180000000;
  localparam logic signed [AngleW-1:0] LatLimitNeg = -29'sd90000000;
  localparam logic signed [AngleW-1:0] LonLimitNeg = -29'sd180000000;

  // Reciprocal constants for division by constants.
  // deg = (mag * RecipMicro) >> 48, exact for mag below 2^28.
  localparam logic [28:0] RecipMicro = 29'd281474977;
  // hund = (num * RecipThousand) >> 33, exact for num below 2^23.
  localparam logic [23:0] RecipThousand = 24'd8589935;

  localparam logic [12:0] HundPerDeg = 13'd6000;
  localparam logic [7:0]  AmbMax     = 8'd4;

  // ASCII codes.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharN     = 8'h4E;
  localparam logic [7:0] CharS     = 8'h53;
  localparam logic [7:0] CharE     = 8'h45;
  localparam logic [7:0] CharW     = 8'h57;

  // One formatted field, first character in chars[0].
  typedef struct packed {
    logic [NChars-1:0][7:0] chars;
    logic                   lon;
    logic                   clamped;
  } fmt_item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = CharZero + {4'b0000, d};
  endfunction

endpackage

@@ rtl/core/aprs_pos_in_if.sv @@
`timescale 1ns / 1ps
interface aprs_pos_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [28:0]       angle_microdeg;

  modport source (output valid, mode, angle_microdeg, input ready);
  modport sink   (input valid, mode, angle_microdeg, output ready);
endinterface

@@ rtl/core/aprs_pos_out_if.sv @@
`timescale 1ns / 1ps
interface aprs_pos_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  logic       clamped;

  modport source (output valid, char_code, last, clamped, input ready);
  modport sink   (input valid, char_code, last, clamped, output ready);
endinterface

@@ rtl/core/aprs_pos_fmt.sv @@
`timescale 1ns / 1ps
`include "aprs_position_text_formatter_top_assert.svh"
// Seven-stage arithmetic pipeline: clamp, degree split, minute rounding,
// decimal digit extraction and text assembly of one position field.
module aprs_pos_fmt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic signed [aprs_pos_pkg::AngleW-1:0] in_angle,
  input  logic [aprs_pos_pkg::AmbW-1:0]   amb,
  output logic                            item_valid,
  input  logic                            item_ready,
  output aprs_pos_pkg::fmt_item_t         item
);

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic [7:1] v_r;
  logic [8:1] en;

  always_comb begin
    en[8] = item_ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_ready   = en[1];
  assign item_valid = v_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Flags that ride along every stage up to text assembly.
  logic [6:1] lon_r, neg_r, clp_r;

  // Stage 1: clamp to the limit of the selected axis and take the magnitude.
  logic signed [aprs_pos_pkg::AngleW-1:0] lim_hi, lim_lo, a_cl;
  logic        clp_nxt, neg_nxt;
  logic [aprs_pos_pkg::AngleW-1:0] abs_w;
  logic [aprs_pos_pkg::MagW-1:0]   mag1_r;

  always_comb begin
    lim_hi  = in_mode ? aprs_pos_pkg::LonLimit : aprs_pos_pkg::LatLimit;
    lim_lo  = in_mode ? aprs_pos_pkg::LonLimitNeg : aprs_pos_pkg::LatLimitNeg;
    a_cl    = in_angle;
    clp_nxt = 1'b0;
    if (in_angle > lim_hi) begin
      a_cl    = lim_hi;
      clp_nxt = 1'b1;
    end else if (in_angle < lim_lo) begin
      a_cl    = lim_lo;
      clp_nxt = 1'b1;
    end
    neg_nxt = a_cl[aprs_pos_pkg::AngleW-1];
    abs_w   = neg_nxt ? -a_cl : a_cl;
  end

  // Flag registers of stages 1 to 6.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      lon_r[1] <= in_mode;
      neg_r[1] <= neg_nxt;
      clp_r[1] <= clp_nxt;
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        lon_r[k] <= lon_r[k-1];
        neg_r[k] <= neg_r[k-1];
        clp_r[k] <= clp_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mag1_r <= abs_w[aprs_pos_pkg::MagW-1:0];
    end
  end

  // Stage 2: reciprocal product for the whole degrees.
  logic [56:0] prod2_r;
  logic [aprs_pos_pkg::MagW-1:0] mag2_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod2_r <= 57'(mag1_r) * 57'(aprs_pos_pkg::RecipMicro);
      mag2_r  <= mag1_r;
    end
  end

  // Stage 3: fraction of a degree, scaled to hundredths of a minute with rounding.
  logic [7:0]  deg3_w;
  logic [27:0] frac3_w;
  logic [22:0] num3_w;
  logic [7:0]  deg3_r;
  logic [22:0] num3_r;
  always_comb begin
    deg3_w  = prod2_r[55:48];
    frac3_w = mag2_r - (28'(deg3_w) * 28'd1000000);
    num3_w  = (23'(frac3_w[19:0]) * 23'd6) + 23'd500;
  end
  always_ff @(posedge clk) begin
    if (en[3]) begin
      deg3_r <= deg3_w;
      num3_r <= num3_w;
    end
  end

  // Stage 4: reciprocal product for the division by one thousand.
  logic [46:0] prod4_r;
  logic [7:0]  deg4_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      prod4_r <= 47'(num3_r) * 47'(aprs_pos_pkg::RecipThousand);
      deg4_r  <= deg3_r;
    end
  end

  // Stage 5: a rounded sixty minutes wraps to zero and carries into degrees.
  logic [12:0] hund5_w;
  logic [12:0] hund5_r;
  logic [7:0]  deg5_r;
  assign hund5_w = prod4_r[45:33];
  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (hund5_w >= aprs_pos_pkg::HundPerDeg) begin
        hund5_r <= hund5_w - aprs_pos_pkg::HundPerDeg;
        deg5_r  <= deg4_r + 8'd1;
      end else begin
        hund5_r <= hund5_w;
        deg5_r  <= deg4_r;
      end
    end
  end

  // Stage 6: decimal quotients by reciprocal multiplication.
  logic [28:0] hq10_w;
  logic [25:0] hq100_w;
  logic [26:0] hq1000_w;
  logic [15:0] dq10_w;
  logic [13:0] dq100_w;
  logic [12:0] hund6_r;
  logic [9:0]  hq10_r;
  logic [6:0]  hq100_r;
  logic [3:0]  hq1000_r;
  logic [7:0]  deg6_r;
  logic [4:0]  dq10_r;
  logic [1:0]  dq100_r;
  always_comb begin
    hq10_w   = 29'(hund5_r) * 29'd52429;
    hq100_w  = 26'(hund5_r) * 26'd5243;
    hq1000_w = 27'(hund5_r) * 27'd8389;
    dq10_w   = 16'(deg5_r) * 16'd205;
    dq100_w  = 14'(deg5_r) * 14'd41;
  end
  always_ff @(posedge clk) begin
    if (en[6]) begin
      hund6_r  <= hund5_r;
      hq10_r   <= hq10_w[28:19];
      hq100_r  <= hq100_w[25:19];
      hq1000_r <= hq1000_w[26:23];
      deg6_r   <= deg5_r;
      dq10_r   <= dq10_w[15:11];
      dq100_r  <= dq100_w[13:12];
    end
  end

  // Stage 7: digits, blanking and placement of the characters.
  logic [3:0] hd0, hd1, hd2, hd3, dd0, dd1, dd2;
  logic [7:0] amb_sat;
  logic [7:0][7:0] tail;
  logic [7:0] hemi;
  aprs_pos_pkg::fmt_item_t item_nxt;
  aprs_pos_pkg::fmt_item_t item_r;

  always_comb begin
    hd0 = 4'(hund6_r - (13'(hq10_r) * 13'd10));
    hd1 = 4'(hq10_r - (10'(hq100_r) * 10'd10));
    hd2 = 4'(hq100_r - (7'(hq1000_r) * 7'd10));
    hd3 = hq1000_r;
    dd0 = 4'(deg6_r - (8'(dq10_r) * 8'd10));
    dd1 = 4'(dq10_r - (5'(dq100_r) * 5'd10));
    dd2 = 4'(dq100_r);
    amb_sat = (8'(amb) > aprs_pos_pkg::AmbMax) ? aprs_pos_pkg::AmbMax : 8'(amb);
    if (lon_r[6]) begin
      hemi = neg_r[6] ? aprs_pos_pkg::CharW : aprs_pos_pkg::CharE;
    end else begin
      hemi = neg_r[6] ? aprs_pos_pkg::CharS : aprs_pos_pkg::CharN;
    end
    // Tail in output order: degree tens, units, minutes, point, decimals, letter.
    tail[0] = aprs_pos_pkg::digit_char(dd1);
    tail[1] = aprs_pos_pkg::digit_char(dd0);
    tail[2] = (amb_sat >= 8'd4) ? aprs_pos_pkg::CharSpace : aprs_pos_pkg::digit_char(hd3);
    tail[3] = (amb_sat >= 8'd3) ? aprs_pos_pkg::CharSpace : aprs_pos_pkg::digit_char(hd2);
    tail[4] = aprs_pos_pkg::CharDot;
    tail[5] = (amb_sat >= 8'd2) ? aprs_pos_pkg::CharSpace : aprs_pos_pkg::digit_char(hd1);
    tail[6] = (amb_sat >= 8'd1) ? aprs_pos_pkg::CharSpace : aprs_pos_pkg::digit_char(hd0);
    tail[7] = hemi;
    item_nxt.lon     = lon_r[6];
    item_nxt.clamped = clp_r[6];
    // Longitude puts the hundreds of degrees in front of the tail.
    if (lon_r[6]) begin
      item_nxt.chars[0] = aprs_pos_pkg::digit_char(dd2);
      for (int i = 0; i < 8; i++) begin
        item_nxt.chars[i+1] = tail[i];
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        item_nxt.chars[i] = tail[i];
      end
      item_nxt.chars[8] = aprs_pos_pkg::CharSpace;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      item_r <= item_nxt;
    end
  end
  assign item = item_r;

  // Checks on the arithmetic.
  `APRS_ASSERT_IMPL(a_hund_wrapped, v_r[5], hund5_r < aprs_pos_pkg::HundPerDeg, "minutes not wrapped")
  `APRS_ASSERT_IMPL(a_deg_range, v_r[5], (deg5_r <= 8'd180) && (lon_r[5] || deg5_r <= 8'd90), "degrees out of range")
  `APRS_ASSERT_IMPL(a_thousands, v_r[6], hq1000_r <= 4'd5, "tens of minutes above five")
  `APRS_ASSERT_NEXT(a_stall_hold, v_r[7] && !item_ready, $stable(item_r) && v_r[7], "stalled item changed")

endmodule

@@ rtl/core/aprs_position_text_formatter_top.sv @@
`timescale 1ns / 1ps
// APRS position text formatter. Each input item (mode, signed angle in
// microdegrees) yields one field of text, one ASCII character per output item:
// "ddmm.mmH" (8 items) for latitude or "dddmm.mmH" (9 items) for longitude, with
// last set on the hemisphere letter and clamped repeated on every character.
// The output channel carries one character per cycle while out_ch.ready is high,
// and the arithmetic pipeline can take new input items while a field is being sent;
// the next field is loaded into the output shift register in the same cycle
// that the last character of the previous one is taken. The first character is
// offered once its input item has passed through the seven-stage arithmetic
// pipeline and been loaded into the output shift register.
// cfg_wdata written with cfg_we sets the position ambiguity (values above four
// act as four); write it only while no item is in flight.
`include "aprs_position_text_formatter_top_assert.svh"
module aprs_position_text_formatter_top (
  input  logic                  clk,
  input  logic                  rst_n,
  aprs_pos_in_if.sink           in_ch,
  aprs_pos_out_if.source        out_ch,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_wdata
);

  // Position ambiguity register.
  logic [aprs_pos_pkg::AmbW-1:0] amb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r <= '0;
    end else if (cfg_we) begin
      amb_r <= cfg_wdata;
    end
  end

  // Arithmetic pipeline.
  logic                    item_valid;
  logic                    item_ready;
  aprs_pos_pkg::fmt_item_t item;

  aprs_pos_fmt u_fmt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .in_angle   (in_ch.angle_microdeg),
    .amb        (amb_r),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // Output shift register: one character leaves per taken item.
  logic [aprs_pos_pkg::NChars-1:0][7:0] sh_r;
  logic [3:0] cnt_r;
  logic       clp_r;
  logic       take;
  logic       load;

  assign take       = out_ch.valid && out_ch.ready;
  assign item_ready = (cnt_r == 4'd0) || (out_ch.ready && cnt_r == 4'd1);
  assign load       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= item.lon ? 4'd9 : 4'd8;
    end else if (take) begin
      cnt_r <= cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r  <= item.chars;
      clp_r <= item.clamped;
    end else if (take) begin
      sh_r  <= sh_r >> 8;
    end
  end

  assign out_ch.valid     = cnt_r != 4'd0;
  assign out_ch.char_code = sh_r[0];
  assign out_ch.last      = cnt_r == 4'd1;
  assign out_ch.clamped   = clp_r;

  // Checks on the serializer.
  `APRS_ASSERT_ALWAYS(a_cnt_range, cnt_r <= 4'd9, "character count above nine")
  `APRS_ASSERT_IMPL(a_last_letter, out_ch.valid && out_ch.last, (sh_r[0] == aprs_pos_pkg::CharN) || (sh_r[0] == aprs_pos_pkg::CharS) || (sh_r[0] == aprs_pos_pkg::CharE) || (sh_r[0] == aprs_pos_pkg::CharW), "last character is not a hemisphere letter")
  `APRS_ASSERT_NEXT(a_clamped_steady, out_ch.valid && !out_ch.last, $stable(clp_r), "clamped flag changed inside a field")

endmodule
